// ----- design/qvr_pkg.sv -----
// Shared widths, types and constants for the quaternion vector rotation unit.
// Used by qvr_round and quaternion_vector_rotate_unit; depends on nothing.
package qvr_pkg;

    localparam int VEC_W      = 32;   // Q16.16 vector and result components
    localparam int QUAT_W     = 32;   // Q1.30 quaternion components
    localparam int PP_W       = 64;   // product of two quaternion components
    localparam int MAT_W      = 66;   // rotation matrix entry, 60 fraction bits
    localparam int LO_W       = 33;   // unsigned low slice of a matrix entry
    localparam int HI_W       = MAT_W - LO_W;
    localparam int PL_W       = LO_W + 1 + VEC_W;
    localparam int PH_W       = HI_W + VEC_W;
    localparam int ACC_W      = 100;  // exact component sum, 76 fraction bits
    localparam int FRAC_SHIFT = 60;
    localparam int MAG_W      = ACC_W - FRAC_SHIFT;
    localparam int STAGES     = 7;

    localparam logic [ACC_W-1:0] ROUND_HALF     = ACC_W'(1) << (FRAC_SHIFT - 1);
    localparam logic [ACC_W-1:0] ROUND_HALF_INC = ROUND_HALF + ACC_W'(1);
    localparam logic [MAG_W-1:0] POS_LIMIT      = MAG_W'(32'h7FFF_FFFF);
    localparam logic [MAG_W-1:0] NEG_LIMIT      = MAG_W'(32'h8000_0000);
    localparam logic [VEC_W-1:0] POS_SAT        = 32'h7FFF_FFFF;
    localparam logic [VEC_W-1:0] NEG_SAT        = 32'h8000_0000;

    typedef logic signed [VEC_W-1:0] vec_t;
    typedef logic signed [PP_W-1:0]  pp_t;
    typedef logic signed [MAT_W-1:0] mat_t;
    typedef logic signed [PL_W-1:0]  pl_t;
    typedef logic signed [PH_W-1:0]  ph_t;
    typedef logic signed [ACC_W-1:0] acc_t;

    typedef struct packed {
        logic [VEC_W-1:0] value;
        logic             sat;
    } rnd_out_t;

endpackage

// ----- design/qvr_round.sv -----
// Rounds one exact rotated component to Q16.16 and saturates it, in two stages.
// Depends on qvr_pkg for widths, limits and the result struct.
module qvr_round
(
    input  logic              clk,
    input  qvr_pkg::acc_t     acc,
    output qvr_pkg::rnd_out_t res
);

    logic                           neg_reg;
    logic [qvr_pkg::MAG_W-1:0]      mag_reg;
    logic [qvr_pkg::ACC_W-1:0]      biased;
    qvr_pkg::rnd_out_t              res_reg;
    qvr_pkg::rnd_out_t              res_next;

    // For a negative sum, ~acc + 1 + half is the magnitude plus half in a single add.
    always_comb
    begin
        if (acc[qvr_pkg::ACC_W-1])
        begin
            biased = ~acc + qvr_pkg::ROUND_HALF_INC;
        end
        else
        begin
            biased = acc + qvr_pkg::ROUND_HALF;
        end
    end

    always_comb
    begin
        res_next.sat = 1'b0;
        if (neg_reg)
        begin
            if (mag_reg > qvr_pkg::NEG_LIMIT)
            begin
                res_next.sat   = 1'b1;
                res_next.value = qvr_pkg::NEG_SAT;
            end
            else
            begin
                res_next.value = qvr_pkg::VEC_W'(~mag_reg + qvr_pkg::MAG_W'(1));
            end
        end
        else
        begin
            if (mag_reg > qvr_pkg::POS_LIMIT)
            begin
                res_next.sat   = 1'b1;
                res_next.value = qvr_pkg::POS_SAT;
            end
            else
            begin
                res_next.value = mag_reg[qvr_pkg::VEC_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= acc[qvr_pkg::ACC_W-1];
        mag_reg <= biased[qvr_pkg::ACC_W-1:qvr_pkg::FRAC_SHIFT];
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

// ----- design/quaternion_vector_rotate_unit.sv -----
// Top level of the quaternion vector rotation unit: a seven-stage pipeline.
// Depends on qvr_pkg and instantiates qvr_round once per component.
//
// Usage
//   Input channel: an item (vec_x/y/z in Q16.16, quat_w/x/y/z in Q1.30) is
//   taken at each rising edge where start is high and busy is low. busy is
//   always low, so a new item may be offered in every cycle.
//   Result channel: done is high for exactly one cycle with rot_x/y/z
//   (Q16.16, saturated) and clipped, which is set if any component saturated.
//   Throughput: one item per cycle, set by the fully pipelined multiplier
//   stages (quaternion pair products, matrix entries, split 66 by 32 bit
//   products, term assembly, component sums, rounding and saturation).
//   Reset (rst_n low, asynchronous) clears the valid bits, so no result
//   appears for items that were in flight. The receiver cannot stall, and the
//   pipeline never holds an item back.
module quaternion_vector_rotate_unit
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  qvr_pkg::vec_t        vec_x,
    input  qvr_pkg::vec_t        vec_y,
    input  qvr_pkg::vec_t        vec_z,
    input  qvr_pkg::vec_t        quat_w,
    input  qvr_pkg::vec_t        quat_x,
    input  qvr_pkg::vec_t        quat_y,
    input  qvr_pkg::vec_t        quat_z,
    output logic                 done,
    output qvr_pkg::vec_t        rot_x,
    output qvr_pkg::vec_t        rot_y,
    output qvr_pkg::vec_t        rot_z,
    output logic                 clipped
);

    logic [qvr_pkg::STAGES-1:0] vld_reg;
    logic [qvr_pkg::STAGES-1:0] vld_next;

    // Stage 1: quaternion pair products and the vector
    qvr_pkg::pp_t  ww_reg, xx_reg, yy_reg, zz_reg, xy_reg;
    qvr_pkg::pp_t  wz_reg, xz_reg, wy_reg, yz_reg, wx_reg;
    qvr_pkg::vec_t v1_reg [3];

    // Stage 2: rotation matrix, row major
    qvr_pkg::mat_t m_reg [9];
    qvr_pkg::mat_t m_next [9];
    qvr_pkg::vec_t v2_reg [3];

    // Stage 3: split products
    qvr_pkg::pl_t  pl_reg [9];
    qvr_pkg::ph_t  ph_reg [9];

    // Stage 4: whole terms; stage 5: component sums
    qvr_pkg::acc_t term_reg [9];
    qvr_pkg::acc_t sum_reg [3];

    qvr_pkg::rnd_out_t rnd [3];

    always_comb
    begin
        vld_next = {vld_reg[qvr_pkg::STAGES-2:0], start};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ww_reg    <= quat_w * quat_w;
        xx_reg    <= quat_x * quat_x;
        yy_reg    <= quat_y * quat_y;
        zz_reg    <= quat_z * quat_z;
        xy_reg    <= quat_x * quat_y;
        wz_reg    <= quat_w * quat_z;
        xz_reg    <= quat_x * quat_z;
        wy_reg    <= quat_w * quat_y;
        yz_reg    <= quat_y * quat_z;
        wx_reg    <= quat_w * quat_x;
        v1_reg[0] <= vec_x;
        v1_reg[1] <= vec_y;
        v1_reg[2] <= vec_z;
    end

    always_comb
    begin
        m_next[0] = qvr_pkg::MAT_W'(ww_reg) + qvr_pkg::MAT_W'(xx_reg)
                  - qvr_pkg::MAT_W'(yy_reg) - qvr_pkg::MAT_W'(zz_reg);
        m_next[1] = (qvr_pkg::MAT_W'(xy_reg) - qvr_pkg::MAT_W'(wz_reg)) <<< 1;
        m_next[2] = (qvr_pkg::MAT_W'(xz_reg) + qvr_pkg::MAT_W'(wy_reg)) <<< 1;
        m_next[3] = (qvr_pkg::MAT_W'(xy_reg) + qvr_pkg::MAT_W'(wz_reg)) <<< 1;
        m_next[4] = qvr_pkg::MAT_W'(ww_reg) - qvr_pkg::MAT_W'(xx_reg)
                  + qvr_pkg::MAT_W'(yy_reg) - qvr_pkg::MAT_W'(zz_reg);
        m_next[5] = (qvr_pkg::MAT_W'(yz_reg) - qvr_pkg::MAT_W'(wx_reg)) <<< 1;
        m_next[6] = (qvr_pkg::MAT_W'(xz_reg) - qvr_pkg::MAT_W'(wy_reg)) <<< 1;
        m_next[7] = (qvr_pkg::MAT_W'(yz_reg) + qvr_pkg::MAT_W'(wx_reg)) <<< 1;
        m_next[8] = qvr_pkg::MAT_W'(ww_reg) - qvr_pkg::MAT_W'(xx_reg)
                  - qvr_pkg::MAT_W'(yy_reg) + qvr_pkg::MAT_W'(zz_reg);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 9; k++)
        begin
            m_reg[k] <= m_next[k];
        end
        for (int c = 0; c < 3; c++)
        begin
            v2_reg[c] <= v1_reg[c];
        end
    end

    // Each matrix entry is cut into an unsigned low slice and a signed high
    // slice, so that every multiplier stays close to 32 by 32 bits.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 9; k++)
        begin
            pl_reg[k] <= qvr_pkg::PL_W'($signed({1'b0, m_reg[k][qvr_pkg::LO_W-1:0]}))
                         * qvr_pkg::PL_W'(v2_reg[k % 3]);
            ph_reg[k] <= qvr_pkg::PH_W'($signed(m_reg[k][qvr_pkg::MAT_W-1:qvr_pkg::LO_W]))
                         * qvr_pkg::PH_W'(v2_reg[k % 3]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 9; k++)
        begin
            term_reg[k] <= (qvr_pkg::ACC_W'(ph_reg[k]) <<< qvr_pkg::LO_W)
                           + qvr_pkg::ACC_W'(pl_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            sum_reg[i] <= term_reg[3*i] + term_reg[3*i+1] + term_reg[3*i+2];
        end
    end

    qvr_round u_round_x
    (
        .clk (clk),
        .acc (sum_reg[0]),
        .res (rnd[0])
    );

    qvr_round u_round_y
    (
        .clk (clk),
        .acc (sum_reg[1]),
        .res (rnd[1])
    );

    qvr_round u_round_z
    (
        .clk (clk),
        .acc (sum_reg[2]),
        .res (rnd[2])
    );

    assign busy    = 1'b0;
    assign done    = vld_reg[qvr_pkg::STAGES-1];
    assign rot_x   = rnd[0].value;
    assign rot_y   = rnd[1].value;
    assign rot_z   = rnd[2].value;
    assign clipped = rnd[0].sat | rnd[1].sat | rnd[2].sat;

endmodule

// ----- verif/qvr_result_checker.sv -----
`timescale 1ns / 100ps
// Result checker for quaternion_vector_rotate_unit: predicts each rotation and
// compares it with the result stream. Depends on qvr_pkg for the field types.
module qvr_result_checker
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          busy,
    input  qvr_pkg::vec_t vec_x,
    input  qvr_pkg::vec_t vec_y,
    input  qvr_pkg::vec_t vec_z,
    input  qvr_pkg::vec_t quat_w,
    input  qvr_pkg::vec_t quat_x,
    input  qvr_pkg::vec_t quat_y,
    input  qvr_pkg::vec_t quat_z,
    input  logic          done,
    input  qvr_pkg::vec_t rot_x,
    input  qvr_pkg::vec_t rot_y,
    input  qvr_pkg::vec_t rot_z,
    input  logic          clipped,
    output int            fail_count,
    output int            outstanding
);

    typedef struct {
        qvr_pkg::vec_t rx;
        qvr_pkg::vec_t ry;
        qvr_pkg::vec_t rz;
        logic          clip;
    } rotation_t;

    rotation_t expected_rot_q[$];
    rotation_t want;

    // Rounds a sum with 76 fraction bits to Q16.16, nearest with ties away
    // from zero, and saturates. Bit 32 of the return value is the clip flag.
    function automatic logic [32:0] round_to_q16(input logic signed [127:0] sum);
        logic         neg;
        logic [127:0] mag;
        neg = sum[127];
        mag = neg ? 128'(-sum) : 128'(sum);
        mag = (mag + (128'd1 << 59)) >> 60;
        if (neg)
        begin
            if (mag > 128'h8000_0000)
                return {1'b1, qvr_pkg::NEG_SAT};
            return {1'b0, 32'(~mag + 128'd1)};
        end
        if (mag > 128'h7FFF_FFFF)
            return {1'b1, qvr_pkg::POS_SAT};
        return {1'b0, mag[31:0]};
    endfunction

    // Vector part of q * (0,v) * conj(q), expanded into the rotation matrix
    // built from pairwise quaternion products; nothing is normalised.
    function automatic rotation_t rotate_vector(input qvr_pkg::vec_t vx,
                                                input qvr_pkg::vec_t vy,
                                                input qvr_pkg::vec_t vz,
                                                input qvr_pkg::vec_t qw,
                                                input qvr_pkg::vec_t qx,
                                                input qvr_pkg::vec_t qy,
                                                input qvr_pkg::vec_t qz);
        logic signed [127:0] a, b, c, w, x, y, z;
        logic signed [127:0] ww, xx, yy, zz, wx, wy, wz, xy, xz, yz;
        logic signed [127:0] sx, sy, sz;
        logic [32:0]         ox, oy, oz;
        rotation_t           r;
        a = vx;
        b = vy;
        c = vz;
        w = qw;
        x = qx;
        y = qy;
        z = qz;
        ww = w * w;
        xx = x * x;
        yy = y * y;
        zz = z * z;
        wx = w * x;
        wy = w * y;
        wz = w * z;
        xy = x * y;
        xz = x * z;
        yz = y * z;
        sx = (ww + xx - yy - zz) * a + 2 * (xy - wz) * b + 2 * (xz + wy) * c;
        sy = 2 * (xy + wz) * a + (ww - xx + yy - zz) * b + 2 * (yz - wx) * c;
        sz = 2 * (xz - wy) * a + 2 * (yz + wx) * b + (ww - xx - yy + zz) * c;
        ox = round_to_q16(sx);
        oy = round_to_q16(sy);
        oz = round_to_q16(sz);
        r.rx   = ox[31:0];
        r.ry   = oy[31:0];
        r.rz   = oz[31:0];
        r.clip = ox[32] | oy[32] | oz[32];
        return r;
    endfunction

    initial
    begin
        fail_count  = 0;
        outstanding = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_rot_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result %h %h %h clip %b with no item pending",
                                 $realtime, rot_x, rot_y, rot_z, clipped);
                end
                else
                begin
                    want = expected_rot_q.pop_front();
                    if (rot_x !== want.rx || rot_y !== want.ry || rot_z !== want.rz
                        || clipped !== want.clip)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: expected %h %h %h clip %b, got %h %h %h clip %b",
                                     $realtime, want.rx, want.ry, want.rz, want.clip,
                                     rot_x, rot_y, rot_z, clipped);
                    end
                end
            end
            if (start && !busy)
                expected_rot_q.push_back(rotate_vector(vec_x, vec_y, vec_z, quat_w,
                                                       quat_x, quat_y, quat_z));
        end
        outstanding = expected_rot_q.size();
    end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// Stimulus and verdict for quaternion_vector_rotate_unit; the checking is done
// by qvr_result_checker. Depends on qvr_pkg and the unit's RTL.
module tb_top;

    localparam int            QUIET_LIMIT = 5000;
    localparam qvr_pkg::vec_t Q_ONE       = 32'sh4000_0000;
    localparam qvr_pkg::vec_t COS45       = 32'sd759250125;
    localparam qvr_pkg::vec_t V_MAX       = 32'sh7FFF_FFFF;
    localparam qvr_pkg::vec_t V_MIN       = 32'sh8000_0000;

    logic          clk = 1'b0;
    logic          rst_n;
    logic          start;
    logic          busy;
    qvr_pkg::vec_t vec_x, vec_y, vec_z, quat_w, quat_x, quat_y, quat_z;
    logic          done;
    qvr_pkg::vec_t rot_x, rot_y, rot_z;
    logic          clipped;
    int            fail_count;
    int            outstanding;
    int            idle_pct;
    int            quiet_cycles = 0;

    always #10 clk = ~clk;

    quaternion_vector_rotate_unit uut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .vec_x   (vec_x),
        .vec_y   (vec_y),
        .vec_z   (vec_z),
        .quat_w  (quat_w),
        .quat_x  (quat_x),
        .quat_y  (quat_y),
        .quat_z  (quat_z),
        .done    (done),
        .rot_x   (rot_x),
        .rot_y   (rot_y),
        .rot_z   (rot_z),
        .clipped (clipped)
    );

    qvr_result_checker rot_check
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .vec_x       (vec_x),
        .vec_y       (vec_y),
        .vec_z       (vec_z),
        .quat_w      (quat_w),
        .quat_x      (quat_x),
        .quat_y      (quat_y),
        .quat_z      (quat_z),
        .done        (done),
        .rot_x       (rot_x),
        .rot_y       (rot_y),
        .rot_z       (rot_z),
        .clipped     (clipped),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Entered and left at a falling edge; start stays high between
    // back-to-back items.
    task automatic offer(input qvr_pkg::vec_t vx, input qvr_pkg::vec_t vy,
                         input qvr_pkg::vec_t vz, input qvr_pkg::vec_t qw,
                         input qvr_pkg::vec_t qx, input qvr_pkg::vec_t qy,
                         input qvr_pkg::vec_t qz);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start  <= 1'b1;
        vec_x  <= vx;
        vec_y  <= vy;
        vec_z  <= vz;
        quat_w <= qw;
        quat_x <= qx;
        quat_y <= qy;
        quat_z <= qz;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
    endtask

    function automatic qvr_pkg::vec_t pick_corner();
        case ($urandom_range(0, 7))
            0:       return V_MIN;
            1:       return V_MAX;
            2:       return Q_ONE;
            3:       return -Q_ONE;
            4:       return 32'sd0;
            5:       return 32'sd1;
            6:       return -32'sd1;
            default: return qvr_pkg::vec_t'($urandom);
        endcase
    endfunction

    function automatic qvr_pkg::vec_t moderate_vec();
        return $signed($urandom) >>> $urandom_range(0, 16);
    endfunction

    function automatic qvr_pkg::vec_t in_range_quat();
        return qvr_pkg::vec_t'($urandom_range(0, 32'h8000_0000) - 32'h4000_0000);
    endfunction

    task automatic random_item();
        int            kind;
        real           a, b, c, d, n;
        qvr_pkg::vec_t qw, qx, qy, qz;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2, 3:
            begin
                // Rotation by a unit quaternion with a random axis and angle.
                a = real'($urandom_range(0, 2000000)) / 1000000.0 - 1.0;
                b = real'($urandom_range(0, 2000000)) / 1000000.0 - 1.0;
                c = real'($urandom_range(0, 2000000)) / 1000000.0 - 1.0;
                d = real'($urandom_range(0, 2000000)) / 1000000.0 - 1.0;
                n = $sqrt(a * a + b * b + c * c + d * d);
                if (n < 0.01)
                begin
                    a = 1.0;
                    b = 0.0;
                    c = 0.0;
                    d = 0.0;
                    n = 1.0;
                end
                qw = $rtoi(a / n * 1073741824.0);
                qx = $rtoi(b / n * 1073741824.0);
                qy = $rtoi(c / n * 1073741824.0);
                qz = $rtoi(d / n * 1073741824.0);
                offer(moderate_vec(), moderate_vec(), moderate_vec(), qw, qx, qy, qz);
            end
            4, 5:
                offer(moderate_vec(), moderate_vec(), moderate_vec(), in_range_quat(),
                      in_range_quat(), in_range_quat(), in_range_quat());
            6:
                offer(qvr_pkg::vec_t'($urandom), qvr_pkg::vec_t'($urandom),
                      qvr_pkg::vec_t'($urandom), qvr_pkg::vec_t'($urandom),
                      qvr_pkg::vec_t'($urandom), qvr_pkg::vec_t'($urandom),
                      qvr_pkg::vec_t'($urandom));
            7:
                offer(pick_corner(), pick_corner(), pick_corner(), pick_corner(),
                      pick_corner(), pick_corner(), pick_corner());
            default:
            begin
                // Tiny quaternions leave few result bits, so rounding ties turn up.
                qw = qvr_pkg::vec_t'($urandom_range(0, 65536)) - 32'sd32768;
                qx = qvr_pkg::vec_t'($urandom_range(0, 512)) - 32'sd256;
                qy = qvr_pkg::vec_t'($urandom_range(0, 512)) - 32'sd256;
                qz = qvr_pkg::vec_t'($urandom_range(0, 512)) - 32'sd256;
                offer(qvr_pkg::vec_t'($urandom), qvr_pkg::vec_t'($urandom),
                      qvr_pkg::vec_t'($urandom), qw, qx, qy, qz);
            end
        endcase
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("quaternion_vector_rotate_unit verification failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        rst_n    = 1'b0;
        start    = 1'b0;
        vec_x    = '0;
        vec_y    = '0;
        vec_z    = '0;
        quat_w   = '0;
        quat_x   = '0;
        quat_y   = '0;
        quat_z   = '0;
        idle_pct = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        offer(0, 0, 0, 0, 0, 0, 0);
        offer(V_MAX, V_MIN, 1, Q_ONE, 0, 0, 0);
        offer(V_MAX, V_MIN, 1, -Q_ONE, 0, 0, 0);
        offer(V_MIN, V_MIN, V_MIN, Q_ONE, 0, 0, 0);
        // Quarter turns about each axis.
        offer(32'sh1_0000, 0, 0, COS45, 0, 0, COS45);
        offer(0, 32'sh1_0000, 0, COS45, COS45, 0, 0);
        offer(0, 0, 32'sh1_0000, COS45, 0, COS45, 0);
        // Half turns about each axis.
        offer(32'sh3_0000, -32'sh5_0000, 32'sh7_0000, 0, Q_ONE, 0, 0);
        offer(32'sh3_0000, -32'sh5_0000, 32'sh7_0000, 0, 0, -Q_ONE, 0);
        offer(32'sh3_0000, -32'sh5_0000, 32'sh7_0000, 0, 0, 0, Q_ONE);
        // Exact halves, which round away from zero in both signs.
        offer(32'sh2000_0000, -32'sh2000_0000, 32'sh6000_0000, 32'sh8000, 0, 0, 0);
        offer(2, -2, 3, 32'sh2000_0000, 0, 0, 0);
        // |q| squared of four drives every component into saturation.
        offer(Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE);
        offer(-Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE);
        // Quaternions that are not of unit length, among them the Q1.30 extremes.
        offer(V_MIN, V_MIN, V_MIN, V_MIN, V_MIN, V_MIN, V_MIN);
        offer(V_MAX, V_MAX, V_MAX, V_MAX, V_MAX, V_MAX, V_MAX);
        offer(V_MAX, V_MIN, V_MAX, -1, -1, -1, -1);
        offer(32'sh1234_5678, -32'sh0765_4321, 32'sh0ABC_DEF0, Q_ONE + 1, 0, 0, 0);
        offer(32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000, Q_ONE, -Q_ONE,
              Q_ONE, -Q_ONE);
        offer(V_MAX, V_MAX, V_MAX, 0, 0, 0, 0);
        wait_drained();

        idle_pct = 9;
        repeat (280) random_item();
        wait_drained();
        idle_pct = 81;
        repeat (280) random_item();
        wait_drained();
        idle_pct = 0;
        repeat (270) random_item();
        wait_drained();

        repeat (12) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("quaternion_vector_rotate_unit verification clean");
        else
            $display("quaternion_vector_rotate_unit verification failed");
        $finish;
    end

endmodule
